[src/abd_pkg.sv]
// Shared types and constants for the blocklist alert dedupe block.
`default_nettype none
package abd_pkg;

  // 13-bit fragment offset inside the flags/offset word
  localparam logic [15:0] OFFSET_MASK = 16'h1fff;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BLOCK_FULL = 2'd1;
  localparam logic [1:0] ST_SEEN_FULL  = 2'd2;
  localparam logic [1:0] ST_DUPLICATE  = 2'd3;

  // Request function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // Classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_CHECK,
    OP_SKIP
  } op_t;

  typedef enum logic [1:0] {
    ES_IDLE,
    ES_SCAN_BLK,
    ES_SCAN_SEEN,
    ES_FINISH
  } eng_state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] key_a;
    logic [31:0] key_b;
    logic [15:0] ekind;
  } item_t;

  // Queue head as seen by the engine
  typedef struct packed {
    logic  vld;
    item_t item;
  } q_head_t;

endpackage
`default_nettype wire

[src/abd_chan_if.sv]
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface abd_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] entry_addr;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] frag_field;
  logic [15:0] ether_kind;
  modport source (output valid, func, entry_addr, src_addr, dst_addr, frag_field, ether_kind,
                  input ready);
  modport sink (input valid, func, entry_addr, src_addr, dst_addr, frag_field, ether_kind,
                output ready);
endinterface

interface abd_out_if;
  logic        valid;
  logic        ready;
  logic        alert;
  logic        alert_side;
  logic [31:0] alert_addr;
  logic [15:0] ether_kind_out;
  logic [1:0]  status;
  modport source (output valid, alert, alert_side, alert_addr, ether_kind_out, status,
                  input ready);
  modport sink (input valid, alert, alert_side, alert_addr, ether_kind_out, status,
                output ready);
endinterface
`default_nettype wire

[src/ip_blocklist_alert_dedupe.sv]
// IPv4 blocklist matcher; one alert per address while seen table has room.
//
// in_ch carries requests: func 0 loads entry_addr into the blocklist, func 1
// checks a header (src, dst, frag word, ethertype). Every request yields one
// result on out_ch: alert, side, matched address, ethertype and status.
// Headers with a nonzero fragment offset never alert.
// A two-entry queue takes requests while the table engine is busy, so the
// sender sees ready until two requests wait.
// A load scans the blocklist; a header check scans the blocklist and then
// the seen table, and a non-first fragment skips both scans. The scans are
// linear, one entry per cycle through each table's single read port, and
// end by draining the last registered read. Requests are processed one at
// a time: the engine takes the next one only after it has given its result.
// Reset empties both tables (counts to zero), the queue and the result
// register; no clearing pass is needed. When out_ch stalls the result is
// held in its register and the engine waits with the next result ready,
// while the queue keeps accepting until full.
`default_nettype none
module ip_blocklist_alert_dedupe
  import abd_pkg::*;
#(
  parameter int BLOCK_DEPTH = 256,
  parameter int SEEN_DEPTH  = 256
) (
  input wire logic clk,
  input wire logic rst_n,
  abd_in_if.sink   in_ch,
  abd_out_if.source out_ch
);

  q_head_t head;
  logic    pop;

  abd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_func       (in_ch.func),
    .in_entry_addr (in_ch.entry_addr),
    .in_src_addr   (in_ch.src_addr),
    .in_dst_addr   (in_ch.dst_addr),
    .in_frag_field (in_ch.frag_field),
    .in_ether_kind (in_ch.ether_kind),
    .head          (head),
    .pop           (pop)
  );

  abd_engine #(
    .BLOCK_DEPTH (BLOCK_DEPTH),
    .SEEN_DEPTH  (SEEN_DEPTH)
  ) u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_alert          (out_ch.alert),
    .out_alert_side     (out_ch.alert_side),
    .out_alert_addr     (out_ch.alert_addr),
    .out_ether_kind_out (out_ch.ether_kind_out),
    .out_status         (out_ch.status)
  );

  // Engine never retires a request the queue does not hold
  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.vld) else $error("pop from empty queue");

  // A retired request always shows up as a result next cycle
  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_ch.valid) else $error("retired request without result");

  // A full queue always presents work to the engine
  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> head.vld) else $error("queue full but head empty");

  // A duplicate load result never carries an alert
  a_load_no_alert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_DUPLICATE) |-> !out_ch.alert)
    else $error("alert on duplicate load");

endmodule
`default_nettype wire

[src/abd_front.sv]
// Front end: accept and classify requests into a two-entry queue.
`default_nettype none
module abd_front
  import abd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_func,
  input  wire logic [31:0] in_entry_addr,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [31:0] in_dst_addr,
  input  wire logic [15:0] in_frag_field,
  input  wire logic [15:0] in_ether_kind,
  output      q_head_t     head,
  input  wire logic        pop
);

  item_t       q_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  item_t       cls;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;

  // Classify the request
  always_comb begin
    cls.ekind = in_ether_kind;
    if (in_func == FUNC_LOAD) begin
      cls.op    = OP_LOAD;
      cls.key_a = in_entry_addr;
      cls.key_b = in_entry_addr;
    end else begin
      cls.op    = ((in_frag_field & OFFSET_MASK) == 16'd0) ? OP_CHECK : OP_SKIP;
      cls.key_a = in_src_addr;
      cls.key_b = in_dst_addr;
    end
  end

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  assign head.vld  = (cnt_r != 2'd0);
  assign head.item = q_r[rp_r];

endmodule
`default_nettype wire

[src/abd_engine.sv]
// Back end: scan the blocklist and seen tables, update them and register the result.
`default_nettype none
module abd_engine
  import abd_pkg::*;
#(
  parameter int BLOCK_DEPTH = 256,
  parameter int SEEN_DEPTH  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire q_head_t     head,
  output      logic        pop,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        out_alert,
  output      logic        out_alert_side,
  output      logic [31:0] out_alert_addr,
  output      logic [15:0] out_ether_kind_out,
  output      logic [1:0]  out_status
);

  localparam int BCW = $clog2(BLOCK_DEPTH + 1);
  localparam int SCW = $clog2(SEEN_DEPTH + 1);
  localparam int BAW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int SAW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam logic [BCW-1:0] BLK_FULL  = BCW'(BLOCK_DEPTH);
  localparam logic [SCW-1:0] SEEN_FULL = SCW'(SEEN_DEPTH);

  logic [31:0] blk_mem  [BLOCK_DEPTH];
  logic [31:0] seen_mem [SEEN_DEPTH];
  logic [31:0] blk_rd_r, seen_rd_r;

  eng_state_t     state_r, state_nxt;
  logic [BCW-1:0] bcnt_r, bcnt_nxt, bidx_r, bidx_nxt;
  logic [SCW-1:0] scnt_r, scnt_nxt, sidx_r, sidx_nxt;
  logic           pend_r, pend_nxt;
  logic           ha_b_r, ha_b_nxt, hb_b_r, hb_b_nxt;
  logic           ha_s_r, ha_s_nxt, hb_s_r, hb_s_nxt;
  logic           ovld_r, ovld_nxt;
  logic           oal_r, oal_nxt, oside_r, oside_nxt;
  logic [31:0]    oaddr_r, oaddr_nxt;
  logic [15:0]    okind_r, okind_nxt;
  logic [1:0]     ost_r, ost_nxt;
  logic           blk_we, seen_we, out_load;
  logic [31:0]    seen_wd;
  logic           a_new, b_new;
  item_t          it;

  assign it    = head.item;
  assign a_new = ha_b_r && !ha_s_r;
  assign b_new = hb_b_r && !hb_s_r;

  // Next state, scan counters, hit flags and result
  always_comb begin
    state_nxt = state_r;
    bcnt_nxt  = bcnt_r;
    scnt_nxt  = scnt_r;
    bidx_nxt  = bidx_r;
    sidx_nxt  = sidx_r;
    pend_nxt  = 1'b0;
    ha_b_nxt  = ha_b_r;
    hb_b_nxt  = hb_b_r;
    ha_s_nxt  = ha_s_r;
    hb_s_nxt  = hb_s_r;
    oal_nxt   = oal_r;
    oside_nxt = oside_r;
    oaddr_nxt = oaddr_r;
    okind_nxt = okind_r;
    ost_nxt   = ost_r;
    blk_we    = 1'b0;
    seen_we   = 1'b0;
    seen_wd   = it.key_a;
    pop       = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ES_IDLE: begin
        bidx_nxt = '0;
        sidx_nxt = '0;
        ha_b_nxt = 1'b0;
        hb_b_nxt = 1'b0;
        ha_s_nxt = 1'b0;
        hb_s_nxt = 1'b0;
        if (head.vld) begin
          state_nxt = (it.op == OP_SKIP) ? ES_FINISH : ES_SCAN_BLK;
        end
      end
      ES_SCAN_BLK: begin
        if (pend_r) begin
          if (blk_rd_r == it.key_a) ha_b_nxt = 1'b1;
          if (blk_rd_r == it.key_b) hb_b_nxt = 1'b1;
        end
        if (bidx_r < bcnt_r) begin
          pend_nxt = 1'b1;
          bidx_nxt = bidx_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = (it.op == OP_LOAD) ? ES_FINISH : ES_SCAN_SEEN;
        end
      end
      ES_SCAN_SEEN: begin
        if (pend_r) begin
          if (seen_rd_r == it.key_a) ha_s_nxt = 1'b1;
          if (seen_rd_r == it.key_b) hb_s_nxt = 1'b1;
        end
        if (sidx_r < scnt_r) begin
          pend_nxt = 1'b1;
          sidx_nxt = sidx_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = ES_FINISH;
        end
      end
      ES_FINISH: begin
        if (!ovld_r || out_ready) begin
          out_load  = 1'b1;
          pop       = 1'b1;
          state_nxt = ES_IDLE;
          oal_nxt   = 1'b0;
          oside_nxt = 1'b0;
          oaddr_nxt = '0;
          okind_nxt = '0;
          ost_nxt   = ST_OK;
          if (it.op == OP_LOAD) begin
            if (ha_b_r) begin
              ost_nxt = ST_DUPLICATE;
            end else if (bcnt_r >= BLK_FULL) begin
              ost_nxt = ST_BLOCK_FULL;
            end else begin
              blk_we   = 1'b1;
              bcnt_nxt = bcnt_r + 1'b1;
            end
          end else begin
            okind_nxt = it.ekind;
            if (a_new || b_new) begin
              oal_nxt   = 1'b1;
              oside_nxt = !a_new;
              oaddr_nxt = a_new ? it.key_a : it.key_b;
              seen_wd   = oaddr_nxt;
              if (scnt_r >= SEEN_FULL) begin
                ost_nxt = ST_SEEN_FULL;
              end else begin
                seen_we  = 1'b1;
                scnt_nxt = scnt_r + 1'b1;
              end
            end
          end
        end
      end
      default: state_nxt = ES_IDLE;
    endcase
  end

  // Hold the result until taken
  assign ovld_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : ovld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ES_IDLE;
      bcnt_r  <= '0;
      scnt_r  <= '0;
      pend_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bcnt_r  <= bcnt_nxt;
      scnt_r  <= scnt_nxt;
      pend_r  <= pend_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bidx_r  <= bidx_nxt;
    sidx_r  <= sidx_nxt;
    ha_b_r  <= ha_b_nxt;
    hb_b_r  <= hb_b_nxt;
    ha_s_r  <= ha_s_nxt;
    hb_s_r  <= hb_s_nxt;
    oal_r   <= oal_nxt;
    oside_r <= oside_nxt;
    oaddr_r <= oaddr_nxt;
    okind_r <= okind_nxt;
    ost_r   <= ost_nxt;
  end

  // Table memories, one read and one write port each
  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[bcnt_r[BAW-1:0]] <= it.key_a;
    end
    blk_rd_r <= blk_mem[bidx_r[BAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[scnt_r[SAW-1:0]] <= seen_wd;
    end
    seen_rd_r <= seen_mem[sidx_r[SAW-1:0]];
  end

  assign out_valid          = ovld_r;
  assign out_alert          = oal_r;
  assign out_alert_side     = oside_r;
  assign out_alert_addr     = oaddr_r;
  assign out_ether_kind_out = okind_r;
  assign out_status         = ost_r;

endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for the IPv4 blocklist matcher: random and directed requests checked against a model.
module tb;
  import abd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLK_DEPTH  = 256;
  localparam int SEEN_DEPTH = 256;
  localparam int WATCHDOG   = 200000;

  typedef struct {
    logic        func;
    logic [31:0] entry_addr;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] frag_field;
    logic [15:0] ether_kind;
  } hdr_req_t;

  typedef struct {
    logic        alert;
    logic        side;
    logic [31:0] addr;
    logic [15:0] ekind;
    logic [1:0]  status;
  } alert_res_t;

  logic clk;
  logic rst_n;

  abd_in_if  in_ch ();
  abd_out_if out_ch ();

  ip_blocklist_alert_dedupe #(.BLOCK_DEPTH(BLK_DEPTH), .SEEN_DEPTH(SEEN_DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Blocklist and seen-table model
  logic [31:0] blk_list[$];
  logic [31:0] seen_list[$];
  logic [31:0] addr_pool[$];

  hdr_req_t   pending_reqs[$];
  alert_res_t expected_alerts[$];

  int n_err;
  int n_sent;
  int n_recv;
  int n_alerts;
  int idle_cycles;
  bit stim_done;
  bit quiet_mode;
  int in_gap;
  int out_gap;

  function automatic bit listed(ref logic [31:0] tab[$], input logic [31:0] a);
    foreach (tab[i]) if (tab[i] == a) return 1;
    return 0;
  endfunction

  function automatic alert_res_t predict_alert(hdr_req_t r);
    alert_res_t e;
    e = '{alert: 0, side: 0, addr: '0, ekind: '0, status: ST_OK};
    if (r.func == FUNC_LOAD) begin
      if (listed(blk_list, r.entry_addr)) e.status = ST_DUPLICATE;
      else if (blk_list.size() >= BLK_DEPTH) e.status = ST_BLOCK_FULL;
      else blk_list.push_back(r.entry_addr);
    end else begin
      e.ekind = r.ether_kind;
      if ((r.frag_field & OFFSET_MASK) == 0) begin
        if (listed(blk_list, r.src_addr) && !listed(seen_list, r.src_addr)) begin
          e.alert = 1; e.addr = r.src_addr;
        end else if (listed(blk_list, r.dst_addr) && !listed(seen_list, r.dst_addr)) begin
          e.alert = 1; e.side = 1; e.addr = r.dst_addr;
        end
        if (e.alert) begin
          if (seen_list.size() >= SEEN_DEPTH) e.status = ST_SEEN_FULL;
          else seen_list.push_back(e.addr);
        end
      end
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    $display("tb: mismatch on result %0d: %s got 0x%0h expected 0x%0h", n_recv, what, got,
             exp_v);
    n_err++;
  endtask

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: present the head of the pending queue, with random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
      in_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_alert_push(pending_reqs.pop_front());
        n_sent++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the request
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 0;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 4);
        in_ch.valid <= 0;
      end else if (pending_reqs.size() > 0) begin
        in_ch.valid      <= 1;
        in_ch.func       <= pending_reqs[0].func;
        in_ch.entry_addr <= pending_reqs[0].entry_addr;
        in_ch.src_addr   <= pending_reqs[0].src_addr;
        in_ch.dst_addr   <= pending_reqs[0].dst_addr;
        in_ch.frag_field <= pending_reqs[0].frag_field;
        in_ch.ether_kind <= pending_reqs[0].ether_kind;
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  task automatic predict_alert_push(hdr_req_t r);
    expected_alerts.push_back(predict_alert(r));
  endtask

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    alert_res_t e;
    if (!rst_n) begin
      out_ch.ready <= 0;
      out_gap <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles <= 0;
        if (expected_alerts.size() == 0) begin
          $display("tb: unexpected result with nothing pending");
          n_err++;
        end else begin
          e = expected_alerts.pop_front();
          if (out_ch.alert !== e.alert) report_mismatch("alert", out_ch.alert, e.alert);
          if (out_ch.alert_side !== e.side) report_mismatch("side", out_ch.alert_side, e.side);
          if (out_ch.alert_addr !== e.addr) report_mismatch("addr", out_ch.alert_addr, e.addr);
          if (out_ch.ether_kind_out !== e.ekind)
            report_mismatch("ethertype", out_ch.ether_kind_out, e.ekind);
          if (out_ch.status !== e.status) report_mismatch("status", out_ch.status, e.status);
          if (e.alert) n_alerts++;
        end
        n_recv++;
      end else if (in_ch.valid && in_ch.ready) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 0;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // Pick an address: mostly from the reused pool so hits happen
  function automatic logic [31:0] pick_addr();
    if (addr_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    return $urandom();
  endfunction

  function automatic hdr_req_t make_load(logic [31:0] a);
    hdr_req_t r;
    r = '{func: FUNC_LOAD, entry_addr: a, src_addr: $urandom(), dst_addr: $urandom(),
          frag_field: 16'($urandom()), ether_kind: 16'($urandom())};
    return r;
  endfunction

  function automatic hdr_req_t make_check(logic [31:0] s, logic [31:0] d, logic [15:0] f);
    hdr_req_t r;
    r = '{func: FUNC_CHECK, entry_addr: $urandom(), src_addr: s, dst_addr: d,
          frag_field: f, ether_kind: 16'($urandom())};
    return r;
  endfunction

  function automatic logic [15:0] rand_frag();
    // mostly first fragments, with random flag bits
    if ($urandom_range(0, 4) != 0) return {3'($urandom_range(0, 7)), 13'd0};
    return 16'($urandom());
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_alerts.size() > 0) @(posedge clk);
  endtask

  initial begin
    hdr_req_t r;
    in_ch.valid = 0; in_ch.func = 0; in_ch.entry_addr = 0; in_ch.src_addr = 0;
    in_ch.dst_addr = 0; in_ch.frag_field = 0; in_ch.ether_kind = 0;
    out_ch.ready = 0;
    n_err = 0; n_sent = 0; n_recv = 0; n_alerts = 0;
    stim_done = 0; quiet_mode = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes, duplicate, source/dest hits, seen skip, later fragment
    pending_reqs.push_back(make_load(32'h0000_0000));
    pending_reqs.push_back(make_load(32'hffff_ffff));
    pending_reqs.push_back(make_load(32'hffff_ffff));
    pending_reqs.push_back(make_load(32'h0a00_0001));
    pending_reqs.push_back(make_check(32'h0a00_0001, 32'h0000_0000, 16'h1fff));
    pending_reqs.push_back(make_check(32'h0a00_0001, 32'h0000_0000, 16'he000));
    pending_reqs.push_back(make_check(32'h0a00_0001, 32'h0000_0000, 16'h4000));
    pending_reqs.push_back(make_check(32'h0a00_0001, 32'h0000_0000, 16'h0000));
    pending_reqs.push_back(make_check(32'h1234_5678, 32'hffff_ffff, 16'h0000));
    pending_reqs.push_back(make_check(32'hffff_ffff, 32'h0a00_0001, 16'h0000));
    pending_reqs.push_back(make_check(32'h5555_aaaa, 32'haaaa_5555, 16'h0001));
    r = make_check(32'h0, 32'h0, 16'hffff); r.ether_kind = 16'hffff;
    pending_reqs.push_back(r);
    r = make_check(32'h0, 32'h0, 16'h0000); r.ether_kind = 16'h0000;
    pending_reqs.push_back(r);
    addr_pool.push_back(32'h0); addr_pool.push_back(32'hffff_ffff);
    addr_pool.push_back(32'h0a00_0001);
    // sender holds off until everything has come back
    wait_drained();

    // Random: loads that grow the blocklist, with checks reusing listed addresses
    for (int i = 0; i < 540; i++) begin
      if (i == 400) quiet_mode = 1;
      if ($urandom_range(0, 1) == 0) begin
        r = make_load(pick_addr());
        if (addr_pool.size() < 400) addr_pool.push_back(r.entry_addr);
      end else begin
        r = make_check(pick_addr(), pick_addr(), rand_frag());
      end
      pending_reqs.push_back(r);
      if (pending_reqs.size() > 8) wait_drained();
    end

    // Further first-fragment checks: listed addresses alert once, repeats do not
    for (int i = 0; i < 30; i++) begin
      pending_reqs.push_back(make_check(pick_addr(), pick_addr(), 16'h0));
      if (pending_reqs.size() > 8) wait_drained();
    end
    stim_done = 1;
  end

  // End of run and watchdog
  initial begin
    wait (stim_done);
    wait_drained();
    repeat (1200) @(posedge clk);
    $display("tb: %0d requests, %0d results, %0d alerts; blocklist %0d, seen %0d entries",
             n_sent, n_recv, n_alerts, blk_list.size(), seen_list.size());
    if (n_err == 0 && expected_alerts.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG);
    $display("tb: timeout with %0d results outstanding", expected_alerts.size());
    $display("tb: FAIL");
    $finish;
  end
endmodule

[files.f]
src/abd_pkg.sv
src/abd_chan_if.sv
src/abd_front.sv
src/abd_engine.sv
src/ip_blocklist_alert_dedupe.sv
test/tb.sv
